// File: design/float_block_statistics_unit_defines.svh
// assertion macros used by fbs_ctrl
`ifndef FLOAT_BLOCK_STATISTICS_UNIT_DEFINES_SVH
`define FLOAT_BLOCK_STATISTICS_UNIT_DEFINES_SVH

// property must hold at every clock edge outside reset
`define FBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define FBS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: design/fbs_pkg.sv
`default_nettype none
package fbs_pkg;

  localparam int COUNT_BITS = 24;
  localparam int SUM_W      = 31 + COUNT_BITS;
  localparam int DIV_W      = (SUM_W > 50) ? SUM_W : 50;
  localparam int DVS_W      = (COUNT_BITS > 24) ? COUNT_BITS : 24;
  localparam int DCNT_W     = $clog2(DIV_W + 1);

  localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [7:0]  EXP_SPECIAL    = 8'hFF;

  typedef struct packed {
    logic accept;
    logic align;
    logic add;
    logic norm;
    logic prep;
    logic icap;
    logic fstart;
    logic fcap;
    logic post;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
  } sts_t;

  // leading zeros of a 32-bit word, 32 when zero
  function automatic logic [5:0] clz32(input logic [31:0] x);
    logic [5:0] n;
    logic       found;
    n     = 6'd32;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (x[i] && !found) begin
        n     = 6'(31 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // strict float less-than on raw bits, zeros of either sign compare equal
  function automatic logic flt_lt(input logic [31:0] a, input logic [31:0] b);
    logic r;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
      r = 1'b0;
    end else if (a[31] != b[31]) begin
      r = a[31];
    end else if (!a[31]) begin
      r = a[30:0] < b[30:0];
    end else begin
      r = a[30:0] > b[30:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/fbs_fadd.sv
`default_nettype none
module fbs_fadd import fbs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        align_i,
  input  wire logic        add_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] sum_o
);

  logic        swap;
  logic [31:0] big, sml;
  logic [7:0]  ebig, esml, eeb, ees, d;
  logic [4:0]  sh;
  logic [23:0] msm;
  logic [53:0] w;
  logic [31:0] spec_val;

  logic        sgn_q, sub_q, spec_q;
  logic [7:0]  eeb_q;
  logic [26:0] mbig_q, al_q;
  logic [31:0] specv_q;
  logic [27:0] s_q;

  always_comb begin
    swap = b_i[30:0] > a_i[30:0];
    big  = swap ? b_i : a_i;
    sml  = swap ? a_i : b_i;
    ebig = big[30:23];
    esml = sml[30:23];
    eeb  = (ebig == 8'd0) ? 8'd1 : ebig;
    ees  = (esml == 8'd0) ? 8'd1 : esml;
    d    = eeb - ees;
    sh   = (d > 8'd27) ? 5'd27 : d[4:0];
    msm  = {esml != 8'd0, sml[22:0]};
    w    = {msm, 3'b000, 27'd0} >> sh;
    if (big[22:0] != 23'd0) begin
      spec_val = {big[31], EXP_SPECIAL, 1'b1, big[21:0]};
    end else if (esml == EXP_SPECIAL && (big[31] ^ sml[31])) begin
      spec_val = FP_DEFAULT_NAN;
    end else begin
      spec_val = big;
    end
  end

  always_ff @(posedge clk_i) begin
    if (align_i) begin
      sgn_q   <= big[31];
      sub_q   <= big[31] ^ sml[31];
      eeb_q   <= eeb;
      mbig_q  <= {ebig != 8'd0, big[22:0], 3'b000};
      al_q    <= {w[53:28], w[27] | (|w[26:0])};
      spec_q  <= (ebig == EXP_SPECIAL);
      specv_q <= spec_val;
    end
    if (add_i) begin
      s_q <= sub_q ? ({1'b0, mbig_q} - {1'b0, al_q}) : ({1'b0, mbig_q} + {1'b0, al_q});
    end
  end

  // normalize and round to nearest even
  logic [5:0]  lz;
  logic [7:0]  lim, sft;
  logic [26:0] m;
  logic [8:0]  e9;
  logic [31:0] base, r;
  logic        inc;

  always_comb begin
    lz  = clz32({s_q[26:0], 5'd0});
    lim = eeb_q - 8'd1;
    sft = ({2'b00, lz} > lim) ? lim : {2'b00, lz};
    if (s_q[27]) begin
      m  = {s_q[27:2], s_q[1] | s_q[0]};
      e9 = {1'b0, eeb_q} + 9'd1;
    end else begin
      m  = s_q[26:0] << sft[4:0];
      e9 = {1'b0, eeb_q} - {1'b0, sft};
    end
    base = {e9 - 9'd1, 23'd0} + {8'd0, m[26:3]};
    inc  = m[2] & (m[1] | m[0] | base[0]);
    r    = base + {31'd0, inc};
    if (spec_q) begin
      sum_o = specv_q;
    end else if (s_q == 28'd0) begin
      sum_o = {sgn_q & ~sub_q, 31'd0};
    end else if (r[31:23] >= 9'd255) begin
      sum_o = {sgn_q, EXP_SPECIAL, 23'd0};
    end else begin
      sum_o = {sgn_q, r[30:0]};
    end
  end

endmodule
`default_nettype wire

// File: design/fbs_div.sv
`default_nettype none
module fbs_div import fbs_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [DIV_W-1:0] quo_o,
  output logic                  rem_nz_o
);

  logic [DCNT_W-1:0] cnt_q;
  logic              done_q;
  logic [DIV_W-1:0]  quo_q;
  logic [DVS_W-1:0]  rem_q, dvs_q;
  logic [DVS_W:0]    trial, diff;
  logic              ge;

  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    diff  = trial - {1'b0, dvs_q};
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= DCNT_W'(DIV_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign done_o   = done_q;
  assign quo_o    = quo_q;
  assign rem_nz_o = rem_q != '0;

endmodule
`default_nettype wire

// File: design/fbs_datapath.sv
`default_nettype none
module fbs_datapath import fbs_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire cmd_t         cmd_i,
  output sts_t              sts_o,
  input  wire logic [31:0]  value_bits_i,
  input  wire logic         last_item_i,
  output logic      [191:0] res_data_o,
  output logic      [3:0]   res_flags_o
);

  logic [COUNT_BITS-1:0] cnt_q;
  logic [31:0] min_q, max_q, sum_q, v_q;
  logic [30:0] mmax_q, mmin_q, mnz_q;
  logic [SUM_W-1:0] msum_q;
  logic last_q;

  logic [30:0] mag;
  logic first;
  logic [31:0] fadd_sum;

  assign mag   = value_bits_i[30:0];
  assign first = cnt_q == '0;

  fbs_fadd u_fadd (
    .clk_i  (clk_i),
    .align_i(cmd_i.align),
    .add_i  (cmd_i.add),
    .a_i    (sum_q),
    .b_i    (v_q),
    .sum_o  (fadd_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      mmax_q <= 31'd1;
      mmin_q <= 31'h7FFF_FFFF;
      mnz_q  <= 31'h7FFF_FFFF;
      msum_q <= '0;
      min_q  <= '0;
      max_q  <= '0;
      last_q <= 1'b0;
    end else if (cmd_i.load) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      mmax_q <= 31'd1;
      mmin_q <= 31'h7FFF_FFFF;
      mnz_q  <= 31'h7FFF_FFFF;
      msum_q <= '0;
    end else if (cmd_i.accept) begin
      if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
      if (first || flt_lt(value_bits_i, min_q)) min_q <= value_bits_i;
      if (first || flt_lt(max_q, value_bits_i)) max_q <= value_bits_i;
      if (mag > mmax_q) mmax_q <= mag;
      if (mag < mmin_q) mmin_q <= mag;
      if (mag != 31'd0 && mag < mnz_q) mnz_q <= mag;
      msum_q <= msum_q + SUM_W'(mag);
      last_q <= last_item_i;
    end else if (cmd_i.norm) begin
      sum_q <= fadd_sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) v_q <= value_bits_i;
  end

  // count to float and sum unpack
  logic [31:0] c32;
  logic [5:0]  clzc, lza;
  logic [63:0] cx;
  logic [24:0] mr;
  logic        cinc;
  logic [7:0]  ea_fld, eeff;
  logic [23:0] ma24;

  logic [23:0] mb_q, ma_q;
  logic [5:0]  eb_q;
  logic signed [9:0] ea_q;
  logic        az_q, aspec_q;

  always_comb begin
    c32    = 32'(cnt_q);
    clzc   = clz32(c32);
    cx     = {c32, 32'd0} << clzc;
    cinc   = cx[39] & ((|cx[38:0]) | cx[40]);
    mr     = {1'b0, cx[63:40]} + {24'd0, cinc};
    ea_fld = sum_q[30:23];
    eeff   = (ea_fld == 8'd0) ? 8'd1 : ea_fld;
    ma24   = {ea_fld != 8'd0, sum_q[22:0]};
    lza    = clz32({ma24, 8'd0});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      mb_q    <= mr[24] ? mr[24:1] : mr[23:0];
      eb_q    <= 6'd31 - clzc + {5'd0, mr[24]};
      ma_q    <= ma24 << lza[4:0];
      ea_q    <= $signed({2'b00, eeff}) - 10'sd127 - $signed({4'd0, lza});
      az_q    <= sum_q[30:0] == 31'd0;
      aspec_q <= ea_fld == EXP_SPECIAL;
    end
  end

  // shared divider: magnitude mean first, then float mantissa quotient
  logic             div_start, div_done, div_rnz;
  logic [DIV_W-1:0] div_dvd, div_quo;
  logic [DVS_W-1:0] div_dvs;

  assign div_start = cmd_i.prep | cmd_i.fstart;
  assign div_dvd   = cmd_i.prep ? DIV_W'(msum_q) : DIV_W'({ma_q, 26'd0});
  assign div_dvs   = cmd_i.prep ? DVS_W'(cnt_q) : DVS_W'(mb_q);

  fbs_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quo_o     (div_quo),
    .rem_nz_o  (div_rnz)
  );

  logic [31:0] qmag_q;
  logic [26:0] fq_q;
  logic        frnz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.icap) qmag_q <= div_quo[31:0];
    if (cmd_i.fcap) begin
      fq_q   <= div_quo[26:0];
      frnz_q <= div_rnz;
    end
  end

  // quotient exponent, underflow shift and rounding
  logic signed [9:0] ebias, shs;
  logic [26:0] m27;
  logic [7:0]  expo;
  logic [4:0]  dsh;
  logic [53:0] dw;
  logic [30:0] dbase, dr;
  logic        dinc;
  logic [31:0] mean_d, mean_q;

  always_comb begin
    ebias = ea_q - $signed({4'd0, eb_q}) - $signed({9'd0, ~fq_q[26]}) + 10'sd127;
    m27   = fq_q[26] ? fq_q : {fq_q[25:0], 1'b0};
    shs   = 10'sd1 - ebias;
    if (ebias >= 10'sd1) begin
      expo = 8'(ebias - 10'sd1);
      dsh  = 5'd0;
    end else begin
      expo = 8'd0;
      dsh  = (shs > 10'sd27) ? 5'd27 : shs[4:0];
    end
    dw    = {m27, 27'd0} >> dsh;
    dbase = {expo, 23'd0} + {7'd0, dw[53:30]};
    dinc  = dw[29] & ((|dw[28:0]) | frnz_q | dbase[0]);
    dr    = dbase + {30'd0, dinc};
    if (az_q) begin
      mean_d = {sum_q[31], 31'd0};
    end else if (aspec_q) begin
      mean_d = (sum_q[22:0] != 23'd0) ? {sum_q[31], EXP_SPECIAL, 1'b1, sum_q[21:0]} : sum_q;
    end else begin
      mean_d = {sum_q[31], dr};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.post) mean_q <= mean_d;
  end

  logic [30:0] mnz_out;
  logic        neg, pos;

  assign mnz_out = (mnz_q > mmax_q) ? (mmax_q - 31'd1) : mnz_q;
  assign neg     = min_q[31] & (|min_q[30:0]);
  assign pos     = ~max_q[31] & (|max_q[30:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_data_o  <= {2'b00, qmag_q, mean_q, mnz_out, mmax_q, max_q, min_q};
      res_flags_o <= {neg & pos, pos, neg, mmin_q == 31'd0};
    end
  end

  assign sts_o.last     = last_q;
  assign sts_o.div_done = div_done;

endmodule
`default_nettype wire

// File: design/fbs_ctrl.sv
`default_nettype none
`include "float_block_statistics_unit_defines.svh"
module fbs_ctrl import fbs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_tvalid_i,
  output logic      s_tready_o,
  output logic      m_tvalid_o,
  input  wire logic m_tready_i,
  output cmd_t      cmd_o,
  input  wire sts_t sts_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_ALIGN, S_ADD, S_NORM, S_PREP, S_IDIV, S_FSTART, S_FDIV, S_POST, S_LOAD
  } state_e;

  state_e state_q;
  logic   mvalid_q;
  logic   out_free;

  assign out_free   = !mvalid_q || m_tready_i;
  assign s_tready_o = state_q == S_IDLE;
  assign m_tvalid_o = mvalid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = (state_q == S_IDLE) && s_tvalid_i;
    cmd_o.align  = state_q == S_ALIGN;
    cmd_o.add    = state_q == S_ADD;
    cmd_o.norm   = state_q == S_NORM;
    cmd_o.prep   = state_q == S_PREP;
    cmd_o.icap   = (state_q == S_IDIV) && sts_i.div_done;
    cmd_o.fstart = state_q == S_FSTART;
    cmd_o.fcap   = (state_q == S_FDIV) && sts_i.div_done;
    cmd_o.post   = state_q == S_POST;
    cmd_o.load   = (state_q == S_LOAD) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mvalid_q <= 1'b0;
    end else begin
      if (mvalid_q && m_tready_i) mvalid_q <= 1'b0;
      case (state_q)
        S_IDLE:   if (s_tvalid_i) state_q <= S_ALIGN;
        S_ALIGN:  state_q <= S_ADD;
        S_ADD:    state_q <= S_NORM;
        S_NORM:   state_q <= sts_i.last ? S_PREP : S_IDLE;
        S_PREP:   state_q <= S_IDIV;
        S_IDIV:   if (sts_i.div_done) state_q <= S_FSTART;
        S_FSTART: state_q <= S_FDIV;
        S_FDIV:   if (sts_i.div_done) state_q <= S_POST;
        S_POST:   state_q <= S_LOAD;
        S_LOAD: begin
          if (out_free) begin
            mvalid_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  `FBS_ASSERT(a_cmd_onehot, $onehot0(cmd_o), "more than one datapath command at once")
  `FBS_NEVER(a_done_unexpected, sts_i.div_done && !(state_q == S_IDIV || state_q == S_FDIV), "divider finished outside a wait state")
  `FBS_ASSERT(a_load_shows, cmd_o.load |=> m_tvalid_o, "loaded result not offered")

endmodule
`default_nettype wire

// File: design/float_block_statistics_unit.sv
// each input beat is accepted, then passes the align, add and round steps of the float sum adder
// the last beat of a block then runs the iterative divider, one bit a cycle, once for the
// magnitude mean and once for the float mean
// one result beat per block, held in an output register until taken
// rst_ni is asynchronous and active low: clears the accumulated statistics and the output valid
`default_nettype none
module float_block_statistics_unit import fbs_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [31:0]  s_axis_tdata_i,  // value_bits
  input  wire logic         s_axis_tlast_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // min_value, max_value, max_magnitude, min_nonzero_magnitude, mean_value, mean_magnitude
  output logic      [191:0] m_axis_tdata_o,
  // has_zero, has_negative, has_positive, both_signs
  output logic      [3:0]   m_axis_tuser_o
);

  cmd_t cmd;
  sts_t sts;

  fbs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid_i),
    .s_tready_o(s_axis_tready_o),
    .m_tvalid_o(m_axis_tvalid_o),
    .m_tready_i(m_axis_tready_i),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  fbs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .value_bits_i(s_axis_tdata_i),
    .last_item_i (s_axis_tlast_i),
    .res_data_o  (m_axis_tdata_o),
    .res_flags_o (m_axis_tuser_o)
  );

endmodule
`default_nettype wire
